// ----- rtl/tssg_pkg.sv -----
package tssg_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS_DEF = 16;
  localparam int BPP_DEF       = 3;
  localparam int FW_BITS       = 13;
  localparam int ADDR_BITS     = 26;
  localparam int FW_RESET      = 640;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] vertex_a_x;
    logic [COORD_BITS-1:0] vertex_a_y;
    logic [COORD_BITS-1:0] vertex_b_x;
    logic [COORD_BITS-1:0] vertex_b_y;
    logic [COORD_BITS-1:0] vertex_c_x;
    logic [COORD_BITS-1:0] vertex_c_y;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] span_row;
    logic [COORD_BITS-1:0] span_x_first;
    logic [COORD_BITS:0]   span_x_end;
    logic [ADDR_BITS-1:0]  span_address;
    logic                  span_empty;
    logic                  last_span;
  } out_word_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    DIV_SPLIT,
    DIV_UP_B,
    DIV_UP_E,
    DIV_LO_P,
    DIV_LO_Q
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     span;
    logic     classify;
    logic     div_start;
    logic     div_capture;
    logic     emit;
    div_sel_t div_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flat_top;
    logic flat_bot;
    logic need_lower;
    logic div_done;
  } dp_status_t;

endpackage

// ----- rtl/tssg_div.sv -----
module tssg_div import tssg_pkg::*; #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        if (!diff[DVS_W]) begin
          rem_r <= diff[DVS_W-1:0];
          quo_r <= {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DVS_W-1:0];
          quo_r <= {quo_r[DVD_W-2:0], 1'b0};
        end
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ----- rtl/tssg_ctrl.sv -----
module tssg_ctrl import tssg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_op,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt;

  always_comb begin
    state_nxt       = state_r;
    sel_nxt         = sel_r;
    cmd             = '0;
    cmd.div_sel     = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CLASS;
          end else begin
            cmd.span  = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        if (status.flat_top && status.flat_bot) begin
          state_nxt = ST_IDLE;
        end else if (status.flat_bot) begin
          sel_nxt   = DIV_UP_B;
          state_nxt = ST_DIV_GO;
        end else if (status.flat_top) begin
          sel_nxt   = DIV_LO_P;
          state_nxt = ST_DIV_GO;
        end else begin
          sel_nxt   = DIV_SPLIT;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          state_nxt       = ST_DIV_GO;
          case (sel_r)
            DIV_SPLIT: sel_nxt = DIV_UP_B;
            DIV_UP_B:  sel_nxt = DIV_UP_E;
            DIV_LO_P:  sel_nxt = DIV_LO_Q;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        // upper half of a split triangle done: set up the lower edges
        if (status.need_lower) begin
          sel_nxt   = DIV_LO_P;
          state_nxt = ST_DIV_GO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= DIV_SPLIT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/tssg_dp.sv -----
module tssg_dp import tssg_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int BYTES_PER_PIXEL = BPP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  in_word_t           in_word,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic               cfg_we,
  input  logic [FW_BITS-1:0] cfg_data,
  output logic               out_valid,
  output out_word_t          out_word
);

  localparam int C     = COORD_BITS;
  localparam int POS_W = C + FRAC_BITS + 1;
  localparam int DVS_W = C + 1;
  localparam int DVD_W = (C + FRAC_BITS > 2 * C + 2) ? C + FRAC_BITS : 2 * C + 2;
  localparam int N_W   = 2 * C + 3;
  localparam int ROW_W = C + 1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_UPPER = 2'd1;
  localparam logic [1:0] PH_SPLIT = 2'd2;
  localparam logic [1:0] PH_LOWER = 2'd3;

  logic [FW_BITS-1:0]    fw_r;
  logic [C-1:0]          ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [C-1:0]          split_r;
  logic [1:0]            phase_r;
  logic [ROW_W-1:0]      row_r;
  logic signed [POS_W-1:0] lpos_r, rpos_r, lslope_r, rslope_r, tmp_r;
  logic signed [N_W-1:0] n_r;
  logic [C-1:0]          first_r;
  logic [C:0]            end_r;
  logic [ADDR_BITS-1:0]  prod_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;

  // sorting network on the load word
  logic [C-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
  always_comb begin
    tx  = '0; ty = '0;
    sx0 = in_word.vertex_a_x; sy0 = in_word.vertex_a_y;
    sx1 = in_word.vertex_b_x; sy1 = in_word.vertex_b_y;
    sx2 = in_word.vertex_c_x; sy2 = in_word.vertex_c_y;
    if (sy0 > sy2) begin
      tx = sx0; ty = sy0; sx0 = sx2; sy0 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
  end

  // split numerator 2*(by-ay)*(cx-ax) + (cy-ay)
  logic [C-1:0]            d_up, d_lo, d_all;
  logic signed [C:0]       d_cx_ax;
  logic signed [2*C+1:0]   num;
  logic signed [N_W-1:0]   n_nxt;
  assign d_up    = by_r - ay_r;
  assign d_lo    = cy_r - by_r;
  assign d_all   = cy_r - ay_r;
  assign d_cx_ax = $signed({1'b0, cx_r}) - $signed({1'b0, ax_r});
  assign num     = $signed({1'b0, d_up}) * d_cx_ax;
  assign n_nxt   = (N_W'(num) <<< 1) + $signed({{(N_W - C){1'b0}}, d_all});

  // divider operands
  logic [C-1:0]       dxa, dxb, dy;
  logic signed [C:0]  dx;
  logic               dx_neg, n_neg;
  logic [C:0]         dx_mag;
  logic [N_W-1:0]     n_mag;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVD_W-1:0]   quo;
  logic [DVS_W-1:0]   rem;
  logic               div_done;

  always_comb begin
    dxa = cx_r;
    dxb = bx_r;
    dy  = d_lo;
    case (cmd.div_sel)
      DIV_UP_B: begin dxa = bx_r;    dxb = ax_r;    dy = d_up; end
      DIV_UP_E: begin dxa = split_r; dxb = ax_r;    dy = d_up; end
      DIV_LO_P: begin dxa = cx_r;    dxb = split_r; dy = d_lo; end
      default:  begin dxa = cx_r;    dxb = bx_r;    dy = d_lo; end
    endcase
  end

  assign dx     = $signed({1'b0, dxa}) - $signed({1'b0, dxb});
  assign dx_neg = dx[C];
  assign dx_mag = dx_neg ? -dx : dx;
  assign n_neg  = n_r[N_W-1];
  assign n_mag  = n_neg ? -n_r : n_r;

  always_comb begin
    if (cmd.div_sel == DIV_SPLIT) begin
      dvd = DVD_W'(n_mag[N_W-2:0]);
      dvs = {d_all, 1'b0};
    end else begin
      dvd = DVD_W'({dx_mag[C-1:0], {FRAC_BITS{1'b0}}});
      dvs = DVS_W'(dy);
    end
  end

  tssg_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  // slope truncates toward zero, zero-height edge gives 0
  logic signed [POS_W-1:0] q_pos, slope_res;
  assign q_pos     = $signed(POS_W'(quo));
  assign slope_res = (dy == '0) ? '0 : (dx_neg ? -q_pos : q_pos);

  // split x rounded to nearest (floor of value plus one half)
  logic [C+2:0]        q_mag;
  logic signed [C+2:0] q_s, s_sum;
  logic [C-1:0]        split_val;
  assign q_mag = (C+3)'(quo[C+1:0]) + (C+3)'(n_neg && (rem != '0));
  assign q_s   = n_neg ? -$signed(q_mag) : $signed(q_mag);
  assign s_sum = $signed((C+3)'(ax_r)) + q_s;
  always_comb begin
    if (s_sum < 0)
      split_val = '0;
    else if (s_sum > $signed((C+3)'((1 << C) - 1)))
      split_val = '1;
    else
      split_val = s_sum[C-1:0];
  end

  // span edges
  logic [C-1:0]   first_c;
  logic [C:0]     end_c;
  logic [POS_W:0] rsum;
  logic [ADDR_BITS-1:0] prod_c;
  assign first_c = lpos_r[POS_W-1] ? '0 : lpos_r[FRAC_BITS+C-1:FRAC_BITS];
  assign rsum    = {1'b0, rpos_r} + (POS_W+1)'((1 << FRAC_BITS) - 1);
  assign end_c   = rpos_r[POS_W-1] ? '0 : rsum[FRAC_BITS+C:FRAC_BITS];
  assign prod_c  = ADDR_BITS'(row_r * fw_r) + ADDR_BITS'(first_c);

  logic [ROW_W-1:0] row_inc;
  logic             up_end, lo_end;
  assign row_inc = row_r + 1'b1;
  assign up_end  = (row_inc >= {1'b0, by_r});
  assign lo_end  = (row_r <= {1'b0, by_r});

  assign status.flat_top   = (ay_r == by_r);
  assign status.flat_bot   = (by_r == cy_r);
  assign status.need_lower = (phase_r == PH_SPLIT) && up_end;
  assign status.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_BITS'(FW_RESET);
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_we)
        fw_r <= cfg_data;

      if (cmd.load) begin
        ax_r <= sx0; ay_r <= sy0;
        bx_r <= sx1; by_r <= sy1;
        cx_r <= sx2; cy_r <= sy2;
      end

      if (cmd.classify) begin
        n_r <= n_nxt;
        if (status.flat_bot) begin
          split_r <= cx_r;
          phase_r <= status.flat_top ? PH_IDLE : PH_UPPER;
        end else if (status.flat_top) begin
          split_r <= ax_r;
        end else begin
          phase_r <= PH_SPLIT;
        end
      end

      if (cmd.span) begin
        first_r <= first_c;
        end_r   <= end_c;
        prod_r  <= prod_c;
      end

      if (cmd.div_capture) begin
        case (cmd.div_sel)
          DIV_SPLIT: split_r <= split_val;
          DIV_UP_B:  tmp_r   <= slope_res;
          DIV_LO_P:  tmp_r   <= slope_res;
          DIV_UP_E: begin
            if (bx_r < split_r) begin
              lslope_r <= tmp_r;
              rslope_r <= slope_res;
            end else begin
              lslope_r <= slope_res;
              rslope_r <= tmp_r;
            end
            lpos_r <= $signed(POS_W'({ax_r, {FRAC_BITS{1'b0}}}));
            rpos_r <= $signed(POS_W'({ax_r, {FRAC_BITS{1'b0}}}));
            row_r  <= ROW_W'(ay_r);
          end
          default: begin
            if (split_r < bx_r) begin
              lslope_r <= tmp_r;
              rslope_r <= slope_res;
            end else begin
              lslope_r <= slope_res;
              rslope_r <= tmp_r;
            end
            lpos_r  <= $signed(POS_W'({cx_r, {FRAC_BITS{1'b0}}}));
            rpos_r  <= $signed(POS_W'({cx_r, {FRAC_BITS{1'b0}}}));
            row_r   <= ROW_W'(cy_r);
            phase_r <= PH_LOWER;
          end
        endcase
      end

      if (cmd.emit) begin
        if (phase_r == PH_LOWER) begin
          if (lo_end) begin
            phase_r <= PH_IDLE;
          end else begin
            lpos_r <= lpos_r - lslope_r;
            rpos_r <= rpos_r - rslope_r;
            row_r  <= row_r - 1'b1;
          end
        end else if (phase_r != PH_IDLE) begin
          lpos_r <= lpos_r + lslope_r;
          rpos_r <= rpos_r + rslope_r;
          row_r  <= row_inc;
          if (up_end && (phase_r == PH_UPPER))
            phase_r <= PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (phase_r == PH_IDLE) begin
        out_word_r.span_row     <= '0;
        out_word_r.span_x_first <= '0;
        out_word_r.span_x_end   <= '0;
        out_word_r.span_address <= '0;
        out_word_r.span_empty   <= 1'b1;
        out_word_r.last_span    <= 1'b1;
      end else begin
        out_word_r.span_row     <= row_r[C-1:0];
        out_word_r.span_x_first <= first_r;
        out_word_r.span_x_end   <= end_r;
        out_word_r.span_address <= ADDR_BITS'(prod_r * ADDR_BITS'(BYTES_PER_PIXEL));
        out_word_r.span_empty   <= ({1'b0, first_r} >= end_r);
        out_word_r.last_span    <= (phase_r == PH_LOWER) ? lo_end
                                   : ((phase_r == PH_UPPER) && up_end);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- rtl/triangle_scanline_span_generator_unit.sv -----
// Scanline span generator for one triangle at a time. A load word (operation 0) takes
// three vertices, sorts them by y and sets up the edge slopes with a shared
// one-bit-per-cycle divider (dividend width DVD_W = max(12+FRAC_BITS, 26)); a general
// triangle needs three divisions (split x and two upper slopes), a flat one needs two
// and a triangle whose three rows are all equal needs none. A step word (operation 1)
// gives one span on out_word with a one-cycle out_valid strobe: the span edges are
// registered on accept, then the emit state registers the word. The step that ends
// the upper half of a split triangle keeps busy high while the two lower edge slopes
// are set up. Results cannot be held off: the receiver must take each strobed word.
// frame_width is written through cfg_valid/cfg_data; the user must write it only
// while the unit is idle, as the block itself does not enforce this.
module triangle_scanline_span_generator_unit import tssg_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int BYTES_PER_PIXEL = BPP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FW_BITS-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tssg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_word.operation),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  tssg_dp #(.FRAC_BITS(FRAC_BITS), .BYTES_PER_PIXEL(BYTES_PER_PIXEL)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

// ----- rtl/tssg_chk.sv -----
module tssg_chk import tssg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input in_word_t           in_word,
  input logic               out_valid,
  input out_word_t          out_word,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [FW_BITS-1:0] cfg_data
);

  // a step word keeps the unit busy through its span cycle
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.operation == OP_STEP) |=> busy)
    else $error("step accepted but unit not busy");

  // every accepted step word is followed by its span on out_valid
  a_step_span: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.operation == OP_STEP) |-> ##2 out_valid)
    else $error("span missing after step");

  // a load word gives no span
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.operation == OP_LOAD) |-> ##2 !out_valid)
    else $error("span after load");

  a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("spans on consecutive cycles");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.span_empty |->
      ({1'b0, out_word.span_x_first} < out_word.span_x_end))
    else $error("non-empty span with no pixels");

endmodule

bind triangle_scanline_span_generator_unit tssg_chk u_chk (.*);

// ----- dv/triangle_scanline_span_generator_unit_tb.sv -----
module triangle_scanline_span_generator_unit_tb;
  import tssg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int IN_W           = $bits(in_word_t);
  localparam longint ONE = 64'sd1 << FRAC_BITS_DEF;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_word_t           in_word;
  logic               out_valid;
  out_word_t          out_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FW_BITS-1:0] cfg_data;

  // tags that travel with the word being offered
  bit        cur_typed;
  out_word_t cur_want;

  triangle_scanline_span_generator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // span walker state
  longint fw;
  longint vtx[6];
  longint split_pos;
  int     phase;
  longint row;
  longint lpos, rpos, lslope, rslope;

  out_word_t span_q[$];
  int errors;
  int spans_seen, loads_sent, steps_sent;
  int idle_pct;

  function automatic longint wrap_pos(longint v);
    logic signed [28:0] t;
    t = v[28:0];
    return t;
  endfunction

  function automatic longint edge_slope(longint dx, longint dy);
    if (dy == 0) return 0;
    return wrap_pos((dx * ONE) / dy);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic void begin_lower();
    longint sp, sq;
    sp = edge_slope(vtx[4] - split_pos, vtx[5] - vtx[3]);
    sq = edge_slope(vtx[4] - vtx[2], vtx[5] - vtx[3]);
    if (split_pos < vtx[2]) begin
      lslope = sp; rslope = sq;
    end else begin
      lslope = sq; rslope = sp;
    end
    lpos = wrap_pos(vtx[4] * ONE);
    rpos = lpos;
    row = vtx[4 + 1];
    phase = 3;
  endfunction

  function automatic void load_triangle(in_word_t w);
    longint v[3][2];
    longint tx, ty, s, sb, se;
    v[0][0] = w.vertex_a_x; v[0][1] = w.vertex_a_y;
    v[1][0] = w.vertex_b_x; v[1][1] = w.vertex_b_y;
    v[2][0] = w.vertex_c_x; v[2][1] = w.vertex_c_y;
    if (v[0][1] > v[2][1]) begin
      tx = v[0][0]; ty = v[0][1]; v[0] = v[2]; v[2][0] = tx; v[2][1] = ty;
    end
    if (v[0][1] > v[1][1]) begin
      tx = v[0][0]; ty = v[0][1]; v[0] = v[1]; v[1][0] = tx; v[1][1] = ty;
    end
    if (v[1][1] > v[2][1]) begin
      tx = v[1][0]; ty = v[1][1]; v[1] = v[2]; v[2][0] = tx; v[2][1] = ty;
    end
    for (int i = 0; i < 3; i++) begin
      vtx[2*i] = v[i][0]; vtx[2*i+1] = v[i][1];
    end
    if (vtx[3] == vtx[5]) begin
      split_pos = vtx[4];
      phase = 1;
    end else if (vtx[1] == vtx[3]) begin
      split_pos = vtx[0];
      begin_lower();
      return;
    end else begin
      s = vtx[0] + div_floor(2 * (vtx[3] - vtx[1]) * (vtx[4] - vtx[0]) + (vtx[5] - vtx[1]),
                             2 * (vtx[5] - vtx[1]));
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      split_pos = s;
      phase = 2;
    end
    // all three rows equal: nothing to draw
    if (vtx[1] == vtx[3]) begin
      phase = 0; row = 0; lpos = 0; rpos = 0; lslope = 0; rslope = 0;
      return;
    end
    sb = edge_slope(vtx[2] - vtx[0], vtx[3] - vtx[1]);
    se = edge_slope(split_pos - vtx[0], vtx[3] - vtx[1]);
    if (vtx[2] < split_pos) begin
      lslope = sb; rslope = se;
    end else begin
      lslope = se; rslope = sb;
    end
    lpos = wrap_pos(vtx[0] * ONE);
    rpos = lpos;
    row = vtx[1];
  endfunction

  function automatic out_word_t next_span();
    out_word_t r;
    longint first, stop, addr;
    bit fin;
    fin = 1'b0;
    if (phase == 0) begin
      r = '0; r.span_empty = 1'b1; r.last_span = 1'b1;
      return r;
    end
    first = (lpos < 0) ? 0 : lpos / ONE;
    if (first > 4095) first = 4095;
    stop = (rpos < 0) ? 0 : (rpos + ONE - 1) / ONE;
    if (stop > 4096) stop = 4096;
    addr = (row * fw + first) * BPP_DEF;
    r.span_row     = row[COORD_BITS-1:0];
    r.span_x_first = first[COORD_BITS-1:0];
    r.span_x_end   = stop[COORD_BITS:0];
    r.span_address = addr[ADDR_BITS-1:0];
    r.span_empty   = (first >= stop);
    if (phase == 3) begin
      if (row <= vtx[3]) begin
        fin = 1'b1; phase = 0;
      end else begin
        lpos = wrap_pos(lpos - lslope);
        rpos = wrap_pos(rpos - rslope);
        row--;
      end
    end else begin
      lpos = wrap_pos(lpos + lslope);
      rpos = wrap_pos(rpos + rslope);
      row++;
      if (row >= vtx[3]) begin
        if (phase == 2) begin_lower();
        else begin
          fin = 1'b1; phase = 0;
        end
      end
    end
    r.last_span = fin;
    return r;
  endfunction

  task automatic field_mismatch(string name, longint want, longint got);
    $display("%0t: span %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  int idle_cycles;

  always @(posedge clk) begin
    out_word_t e, r;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        fw = cfg_data;
        moved = 1'b1;
      end
      if (start && !busy) begin
        moved = 1'b1;
        if (in_word.operation == OP_LOAD) load_triangle(in_word);
        else begin
          r = next_span();
          span_q.push_back(cur_typed ? cur_want : r);
        end
      end
      if (out_valid) begin
        moved = 1'b1;
        spans_seen++;
        if (span_q.size() == 0) begin
          $display("%0t: unexpected span word, actual %p", $time, out_word);
          errors++;
        end else begin
          e = span_q.pop_front();
          if (e.span_row != out_word.span_row)
            field_mismatch("row", e.span_row, out_word.span_row);
          if (e.span_x_first != out_word.span_x_first)
            field_mismatch("x_first", e.span_x_first, out_word.span_x_first);
          if (e.span_x_end != out_word.span_x_end)
            field_mismatch("x_end", e.span_x_end, out_word.span_x_end);
          if (e.span_address != out_word.span_address)
            field_mismatch("address", e.span_address, out_word.span_address);
          if (e.span_empty != out_word.span_empty)
            field_mismatch("empty", e.span_empty, out_word.span_empty);
          if (e.last_span != out_word.last_span)
            field_mismatch("last", e.last_span, out_word.last_span);
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
        $display("triangle_scanline_span_generator_unit_tb: errors");
        $finish;
      end
    end
  end

  function automatic in_word_t tri_word(int ax, int ay, int bx, int by, int cx, int cy);
    in_word_t w;
    w.operation = OP_LOAD;
    w.vertex_a_x = COORD_BITS'(ax); w.vertex_a_y = COORD_BITS'(ay);
    w.vertex_b_x = COORD_BITS'(bx); w.vertex_b_y = COORD_BITS'(by);
    w.vertex_c_x = COORD_BITS'(cx); w.vertex_c_y = COORD_BITS'(cy);
    return w;
  endfunction

  function automatic in_word_t step_word();
    in_word_t w;
    w = '0;
    w.operation = OP_STEP;
    return w;
  endfunction

  task automatic send(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    in_word   <= w;
    cur_typed <= typed;
    cur_want  <= want;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    if (w.operation == OP_LOAD) loads_sent++;
    else steps_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    // a load may still be setting up its slopes
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(int v);
    cfg_data  <= FW_BITS'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int near_coord(int base, int spread);
    int c;
    c = base + $urandom_range(0, 2 * spread) - spread;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c;
  endfunction

  task automatic random_triangle();
    in_word_t w;
    int bx, by, spread, lo, hi, n;
    if ($urandom_range(0, 19) == 0) begin
      // noise: any field pattern, either operation
      w = IN_W'({$urandom, $urandom, $urandom});
      send(w);
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      w = tri_word($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      n = $urandom_range(1, 6);
    end else begin
      bx = $urandom_range(0, 4095);
      by = $urandom_range(0, 4095);
      spread = $urandom_range(0, 12);
      w = tri_word(near_coord(bx, 3 * spread), near_coord(by, spread),
                   near_coord(bx, 3 * spread), near_coord(by, spread),
                   near_coord(bx, 3 * spread), near_coord(by, spread));
      lo = w.vertex_a_y; hi = w.vertex_a_y;
      if (w.vertex_b_y < lo) lo = w.vertex_b_y;
      if (w.vertex_c_y < lo) lo = w.vertex_c_y;
      if (w.vertex_b_y > hi) hi = w.vertex_b_y;
      if (w.vertex_c_y > hi) hi = w.vertex_c_y;
      n = hi - lo + 1 + $urandom_range(0, 2);
      // cut some triangles short so a new load lands mid-walk
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    end
    send(w);
    repeat (n) send(step_word());
  endtask

  stim_row_t dir_rows[$];

  function automatic void add_row(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    stim_row_t r;
    r.w = w; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endfunction

  initial begin
    out_word_t done_span;
    int widths[6];
    int phase_idle[5];
    int budget;
    widths = '{1, 4096, 8191, 0, 1920, 17};
    phase_idle = '{0, 60, 0, 25, 40};
    fw = FW_RESET;
    for (int i = 0; i < 6; i++) vtx[i] = 0;
    split_pos = 0; phase = 0; row = 0; lpos = 0; rpos = 0; lslope = 0; rslope = 0;
    errors = 0; spans_seen = 0; loads_sent = 0; steps_sent = 0; idle_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0; start = 1'b0; in_word = '0; cfg_valid = 1'b0; cfg_data = '0;
    cur_typed = 1'b0; cur_want = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    done_span = '0;
    done_span.span_empty = 1'b1;
    done_span.last_span = 1'b1;
    add_row(step_word(), 1'b1, done_span);
    add_row(tri_word(100, 50, 300, 50, 200, 50));
    add_row(step_word(), 1'b1, done_span);
    // general triangle given bottom-first, walks through the split
    add_row(tri_word(20, 14, 4, 10, 30, 6));
    for (int i = 0; i < 9; i++) add_row(step_word());
    add_row(step_word(), 1'b1, done_span);
    // flat top, then flat bottom at the far corner
    add_row(tri_word(4095, 4093, 4090, 4093, 4095, 4095));
    repeat (3) add_row(step_word());
    add_row(tri_word(0, 4095, 4095, 4095, 0, 4092));
    repeat (4) add_row(step_word());
    // full-size triangle, replaced after a couple of rows
    add_row(tri_word(0, 0, 4095, 4095, 0, 4095));
    repeat (2) add_row(step_word());
    foreach (dir_rows[i]) send(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_width(p == 4 ? $urandom_range(1, 8191) : widths[p]);
      idle_pct = phase_idle[p];
      budget = steps_sent + loads_sent + 385;
      while (steps_sent + loads_sent < budget) random_triangle();
      drain();
    end
    write_width(widths[5]);
    write_width(FW_RESET);
    add_row(tri_word(7, 3, 1, 5, 12, 8));
    for (int i = 0; i < 7; i++) send(i == 0 ? tri_word(7, 3, 1, 5, 12, 8) : step_word());
    drain();

    $display("covered %0d loads and %0d steps, %0d spans checked", loads_sent, steps_sent,
             spans_seen);
    $display("frame widths from 0 to 8191, sender gaps from none to 60 in 100");
    if (errors == 0 && span_q.size() == 0)
      $display("triangle_scanline_span_generator_unit_tb: clean");
    else
      $display("triangle_scanline_span_generator_unit_tb: errors");
    $finish;
  end

endmodule

// ----- triangle_scanline_span_generator_unit.f -----
rtl/tssg_pkg.sv
rtl/tssg_div.sv
rtl/tssg_ctrl.sv
rtl/tssg_dp.sv
rtl/triangle_scanline_span_generator_unit.sv
rtl/tssg_chk.sv
dv/triangle_scanline_span_generator_unit_tb.sv
